/* rtl/vpfa_pkg.sv */
// ----------------------------------------------------------------------------
// vpfa_pkg
// Shared types, constants and helpers of the variable partition fit allocator.
// ----------------------------------------------------------------------------
package vpfa_pkg;

  localparam int MAX_REGIONS = 32;
  localparam int ADDR_BITS   = 16;
  localparam int OWNER_BITS  = 8;

  localparam int IDX_W     = $clog2(MAX_REGIONS);
  localparam int CNT_W     = $clog2(MAX_REGIONS + 1);
  localparam int SIZE_W    = ADDR_BITS + 1;
  localparam int TREE_LVLS = IDX_W;
  localparam int NLEAF     = 1 << IDX_W;

  // fixed field widths of the channels
  localparam int OWNER_IN_W = 8;
  localparam int REQ_W      = 17;
  localparam int STATUS_W   = 2;
  localparam int START_W    = 16;
  localparam int FREED_W    = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic CFG_MEM_SIZE = 1'b0;
  localparam logic CFG_FIT_MODE = 1'b1;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RESET_MEM_SIZE = 17'd1024;
  localparam logic [SIZE_W:0]       MEM_CAP        = (SIZE_W+1)'(1) << ADDR_BITS;

  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [SIZE_W-1:0]     size_t;
  typedef logic [OWNER_BITS-1:0] owner_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef struct packed {
    addr_t  start;
    addr_t  last;
    logic   free;
    owner_t owner;
  } region_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INIT,
    CELL_OWN,
    CELL_SPLIT_TAIL,
    CELL_SHIFT_L,
    CELL_SHIFT_R,
    CELL_ABSORB_R,
    CELL_RELEASE
  } cell_cmd_e;

  typedef struct packed {
    owner_t owner;
    size_t  req;
    addr_t  new_start;
    addr_t  new_last;
  } cell_bcast_t;

  typedef struct packed {
    logic  fit;
    size_t size;
    logic  owned;
  } cell_stat_t;

  typedef struct packed {
    logic  fit;
    size_t size;
    addr_t start;
    idx_t  idx;
    cnt_t  owned;
  } leaf_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_MERGE,
    S_DONE
  } state_e;

  // Last address of the single free region after (re)initialization.
  function automatic addr_t init_last(logic [CFG_DATA_W-1:0] v);
    logic [SIZE_W:0] vx;
    vx = (SIZE_W+1)'(v);
    if (vx == '0) begin
      return '0;
    end else if (vx > MEM_CAP) begin
      return '1;
    end else begin
      return ADDR_BITS'(vx - (SIZE_W+1)'(1));
    end
  endfunction

endpackage

/* rtl/vpfa_in_if.sv */
// ----------------------------------------------------------------------------
// vpfa_in_if
// Request channel: opcode, owner and requested size.
// ----------------------------------------------------------------------------
interface vpfa_in_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic [vpfa_pkg::OWNER_IN_W-1:0]    owner_id;
  logic [vpfa_pkg::REQ_W-1:0]         request_size;

  modport source (output valid, opcode, owner_id, request_size, input ready);
  modport sink   (input valid, opcode, owner_id, request_size, output ready);
endinterface

/* rtl/vpfa_out_if.sv */
// ----------------------------------------------------------------------------
// vpfa_out_if
// Result channel: status, block start and freed region count.
// ----------------------------------------------------------------------------
interface vpfa_out_if;
  logic                            valid;
  logic                            ready;
  logic [vpfa_pkg::STATUS_W-1:0]   status;
  logic [vpfa_pkg::START_W-1:0]    block_start;
  logic [vpfa_pkg::FREED_W-1:0]    regions_freed;

  modport source (output valid, status, block_start, regions_freed, input ready);
  modport sink   (input valid, status, block_start, regions_freed, output ready);
endinterface

/* rtl/vpfa_cfg_if.sv */
// ----------------------------------------------------------------------------
// vpfa_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface vpfa_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [vpfa_pkg::CFG_IDX_W-1:0]    index;
  logic [vpfa_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/vpfa_cell.sv */
// ----------------------------------------------------------------------------
// vpfa_cell
// One region table entry; loads from its neighbors on insert and merge.
// ----------------------------------------------------------------------------
module vpfa_cell (
  input  logic                  clk,
  input  vpfa_pkg::cell_cmd_e   cmd,
  input  vpfa_pkg::cell_bcast_t bc,
  input  vpfa_pkg::region_t     left,
  input  vpfa_pkg::region_t     right,
  output vpfa_pkg::region_t     region,
  output vpfa_pkg::cell_stat_t  stat
);

  vpfa_pkg::region_t region_r;
  vpfa_pkg::region_t region_nxt;

  // apply the command of this cycle
  always_comb begin
    region_nxt = region_r;
    case (cmd)
      vpfa_pkg::CELL_INIT: begin
        region_nxt.start = '0;
        region_nxt.last  = bc.new_last;
        region_nxt.free  = 1'b1;
        region_nxt.owner = '0;
      end
      vpfa_pkg::CELL_OWN: begin
        region_nxt.last  = bc.new_last;
        region_nxt.free  = 1'b0;
        region_nxt.owner = bc.owner;
      end
      vpfa_pkg::CELL_SPLIT_TAIL: begin
        region_nxt       = left;
        region_nxt.start = bc.new_start;
      end
      vpfa_pkg::CELL_SHIFT_L:  region_nxt = left;
      vpfa_pkg::CELL_SHIFT_R:  region_nxt = right;
      vpfa_pkg::CELL_ABSORB_R: region_nxt.last = right.last;
      vpfa_pkg::CELL_RELEASE: begin
        if (!region_r.free && region_r.owner == bc.owner) begin
          region_nxt.free = 1'b1;
        end
      end
      default: region_nxt = region_r;
    endcase
  end

  always_ff @(posedge clk) begin
    region_r <= region_nxt;
  end

  // local hole size, fit and ownership
  always_comb begin
    stat.size  = {1'b0, region_r.last} - {1'b0, region_r.start} + vpfa_pkg::SIZE_W'(1);
    stat.fit   = region_r.free && (stat.size >= bc.req);
    stat.owned = !region_r.free && (region_r.owner == bc.owner);
  end

  assign region = region_r;

endmodule

/* rtl/vpfa_fit_tree.sv */
// ----------------------------------------------------------------------------
// vpfa_fit_tree
// Registered reduction tree: picks the hole by fit rule, counts owned regions.
// ----------------------------------------------------------------------------
module vpfa_fit_tree (
  input  logic            clk,
  input  logic [1:0]      fit_mode,
  input  vpfa_pkg::leaf_t leaf [vpfa_pkg::MAX_REGIONS],
  output vpfa_pkg::leaf_t root
);

  vpfa_pkg::leaf_t lvl_r [vpfa_pkg::TREE_LVLS+1][vpfa_pkg::NLEAF];

  // lower index wins unless the upper one is strictly better
  function automatic vpfa_pkg::leaf_t combine(vpfa_pkg::leaf_t a, vpfa_pkg::leaf_t b,
                                              logic [1:0] mode);
    logic            take_b;
    vpfa_pkg::leaf_t res;
    take_b = b.fit && (!a.fit ||
             (mode == vpfa_pkg::FIT_BEST  && b.size < a.size) ||
             (mode == vpfa_pkg::FIT_WORST && b.size > a.size));
    res       = take_b ? b : a;
    res.owned = a.owned + b.owned;
    return res;
  endfunction

  // register the leaves; pad unused slots as empty
  for (genvar n = 0; n < vpfa_pkg::NLEAF; n++) begin : g_leaf
    if (n < vpfa_pkg::MAX_REGIONS) begin : g_real
      always_ff @(posedge clk) begin
        lvl_r[0][n] <= leaf[n];
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        lvl_r[0][n] <= '0;
      end
    end
  end

  // one registered level per step
  for (genvar l = 1; l <= vpfa_pkg::TREE_LVLS; l++) begin : g_lvl
    for (genvar n = 0; n < (vpfa_pkg::NLEAF >> l); n++) begin : g_node
      always_ff @(posedge clk) begin
        lvl_r[l][n] <= combine(lvl_r[l-1][2*n], lvl_r[l-1][2*n+1], fit_mode);
      end
    end
  end

  assign root = lvl_r[vpfa_pkg::TREE_LVLS][0];

endmodule

/* rtl/variable_partition_fit_allocator_top.sv */
// An allocate goes from transfer in to result valid through the registered fit tree,
// the apply state and the result state.
// A release adds a merge state that merges one pair of adjacent free regions per step
// until no such pair is left (up to 31 merges).
// Items: one at a time; the next item is taken in the cycle the result turns valid,
// and a held result that stalls the output holds the next item back.
// Reset: synchronous active low; table becomes one free region of 1024 units, first fit.
// ----------------------------------------------------------------------------
// variable_partition_fit_allocator_top
// Region table as a row of cells with first, best or worst fit allocation.
// ----------------------------------------------------------------------------
module variable_partition_fit_allocator_top (
  input  logic          clk,
  input  logic          rst_n,
  vpfa_in_if.sink       in_ch,
  vpfa_out_if.source    out_ch,
  vpfa_cfg_if.sink      cfg_ch
);

  localparam int SCAN_W = $clog2(vpfa_pkg::TREE_LVLS + 1);

  vpfa_pkg::state_e state_r, state_nxt;
  logic [SCAN_W-1:0]         scan_cnt_r, scan_cnt_nxt;
  vpfa_pkg::cnt_t            count_r, count_nxt;
  logic [1:0]                fit_mode_r;
  logic                      op_r;
  vpfa_pkg::owner_t          owner_r;
  vpfa_pkg::size_t           req_r;
  logic [vpfa_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  vpfa_pkg::addr_t           res_start_r, res_start_nxt;
  logic [vpfa_pkg::FREED_W-1:0]  res_freed_r, res_freed_nxt;
  logic                      out_valid_r;
  logic [vpfa_pkg::STATUS_W-1:0] out_status_r;
  logic [vpfa_pkg::START_W-1:0]  out_start_r;
  logic [vpfa_pkg::FREED_W-1:0]  out_freed_r;

  vpfa_pkg::region_t    cell_q   [vpfa_pkg::MAX_REGIONS];
  vpfa_pkg::cell_stat_t cell_st  [vpfa_pkg::MAX_REGIONS];
  vpfa_pkg::cell_cmd_e  cell_cmd [vpfa_pkg::MAX_REGIONS];
  vpfa_pkg::leaf_t      leaf     [vpfa_pkg::MAX_REGIONS];
  vpfa_pkg::leaf_t      root;
  vpfa_pkg::cell_bcast_t bc;

  logic in_xfer, cfg_xfer, out_load, cfg_init;
  logic exact, full, split_ok;
  logic merge_found;
  int   merge_idx;
  vpfa_pkg::size_t req_in;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign cfg_xfer = cfg_ch.valid && cfg_ch.ready;
  assign cfg_init = cfg_xfer && (cfg_ch.index == vpfa_pkg::CFG_MEM_SIZE);
  assign out_load = (state_r == vpfa_pkg::S_DONE) && (!out_valid_r || out_ch.ready);

  assign exact    = (root.size == req_r);
  assign full     = (count_r == vpfa_pkg::CNT_W'(vpfa_pkg::MAX_REGIONS));
  assign split_ok = root.fit && !exact && !full;

  // treat a zero request as one unit
  assign req_in = (in_ch.request_size == '0) ? vpfa_pkg::SIZE_W'(1)
                                             : vpfa_pkg::SIZE_W'(in_ch.request_size);

  // broadcast to the cells
  always_comb begin
    bc.owner     = owner_r;
    bc.req       = req_r;
    bc.new_start = root.start + vpfa_pkg::ADDR_BITS'(req_r);
    if (!rst_n) begin
      bc.new_last = vpfa_pkg::init_last(vpfa_pkg::RESET_MEM_SIZE);
    end else if (state_r == vpfa_pkg::S_APPLY) begin
      bc.new_last = root.start + vpfa_pkg::ADDR_BITS'(req_r - vpfa_pkg::SIZE_W'(1));
    end else begin
      bc.new_last = vpfa_pkg::init_last(cfg_ch.data);
    end
  end

  // row of cells with neighbor links
  for (genvar i = 0; i < vpfa_pkg::MAX_REGIONS; i++) begin : g_cell
    vpfa_pkg::region_t left_q, right_q;
    logic              live;
    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end
    if (i == vpfa_pkg::MAX_REGIONS - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end

    vpfa_cell u_cell (
      .clk    (clk),
      .cmd    (cell_cmd[i]),
      .bc     (bc),
      .left   (left_q),
      .right  (right_q),
      .region (cell_q[i]),
      .stat   (cell_st[i])
    );

    assign live = (vpfa_pkg::CNT_W'(i) < count_r);
    assign leaf[i].fit   = cell_st[i].fit && live;
    assign leaf[i].size  = cell_st[i].size;
    assign leaf[i].start = cell_q[i].start;
    assign leaf[i].idx   = vpfa_pkg::IDX_W'(i);
    assign leaf[i].owned = vpfa_pkg::CNT_W'(cell_st[i].owned && live);
  end

  vpfa_fit_tree u_tree (
    .clk      (clk),
    .fit_mode (fit_mode_r),
    .leaf     (leaf),
    .root     (root)
  );

  // find the lowest pair of adjacent free regions
  always_comb begin
    merge_found = 1'b0;
    merge_idx   = 0;
    for (int i = vpfa_pkg::MAX_REGIONS - 2; i >= 0; i--) begin
      if (cell_q[i].free && cell_q[i+1].free &&
          (vpfa_pkg::CNT_W'(i + 1) < count_r)) begin
        merge_found = 1'b1;
        merge_idx   = i;
      end
    end
  end

  // cell commands
  always_comb begin
    for (int i = 0; i < vpfa_pkg::MAX_REGIONS; i++) begin
      cell_cmd[i] = vpfa_pkg::CELL_HOLD;
    end
    if (!rst_n) begin
      cell_cmd[0] = vpfa_pkg::CELL_INIT;
    end else begin
      case (state_r)
        vpfa_pkg::S_IDLE: begin
          if (cfg_init) begin
            cell_cmd[0] = vpfa_pkg::CELL_INIT;
          end
        end
        vpfa_pkg::S_APPLY: begin
          for (int i = 0; i < vpfa_pkg::MAX_REGIONS; i++) begin
            if (op_r == vpfa_pkg::OP_RELEASE) begin
              cell_cmd[i] = vpfa_pkg::CELL_RELEASE;
            end else if (root.fit && exact) begin
              if (i == int'(root.idx)) cell_cmd[i] = vpfa_pkg::CELL_OWN;
            end else if (split_ok) begin
              if (i == int'(root.idx)) begin
                cell_cmd[i] = vpfa_pkg::CELL_OWN;
              end else if (i == int'(root.idx) + 1) begin
                cell_cmd[i] = vpfa_pkg::CELL_SPLIT_TAIL;
              end else if (i > int'(root.idx) + 1) begin
                cell_cmd[i] = vpfa_pkg::CELL_SHIFT_L;
              end
            end
          end
        end
        vpfa_pkg::S_MERGE: begin
          if (merge_found) begin
            for (int i = 0; i < vpfa_pkg::MAX_REGIONS; i++) begin
              if (i == merge_idx) begin
                cell_cmd[i] = vpfa_pkg::CELL_ABSORB_R;
              end else if (i > merge_idx) begin
                cell_cmd[i] = vpfa_pkg::CELL_SHIFT_R;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vpfa_pkg::S_IDLE:  if (in_xfer) state_nxt = vpfa_pkg::S_SCAN;
      vpfa_pkg::S_SCAN:  if (scan_cnt_r == SCAN_W'(vpfa_pkg::TREE_LVLS)) begin
        state_nxt = vpfa_pkg::S_APPLY;
      end
      vpfa_pkg::S_APPLY: state_nxt = (op_r == vpfa_pkg::OP_RELEASE) ? vpfa_pkg::S_MERGE
                                                                   : vpfa_pkg::S_DONE;
      vpfa_pkg::S_MERGE: if (!merge_found) state_nxt = vpfa_pkg::S_DONE;
      vpfa_pkg::S_DONE:  if (out_load) state_nxt = vpfa_pkg::S_IDLE;
      default:           state_nxt = vpfa_pkg::S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ch.ready  = (state_r == vpfa_pkg::S_IDLE);
    cfg_ch.ready = (state_r == vpfa_pkg::S_IDLE);
  end

  // counters and result
  always_comb begin
    scan_cnt_nxt   = (state_r == vpfa_pkg::S_SCAN) ? scan_cnt_r + SCAN_W'(1) : '0;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    res_freed_nxt  = res_freed_r;
    if (cfg_init && state_r == vpfa_pkg::S_IDLE) begin
      count_nxt = vpfa_pkg::CNT_W'(1);
    end
    if (state_r == vpfa_pkg::S_APPLY) begin
      res_status_nxt = vpfa_pkg::ST_DONE;
      res_start_nxt  = '0;
      res_freed_nxt  = '0;
      if (op_r == vpfa_pkg::OP_RELEASE) begin
        res_freed_nxt = vpfa_pkg::FREED_W'(root.owned);
      end else if (!root.fit) begin
        res_status_nxt = vpfa_pkg::ST_NO_FIT;
      end else if (exact) begin
        res_start_nxt = root.start;
      end else if (full) begin
        res_status_nxt = vpfa_pkg::ST_FULL;
      end else begin
        res_start_nxt = root.start;
        count_nxt     = count_r + vpfa_pkg::CNT_W'(1);
      end
    end
    if (state_r == vpfa_pkg::S_MERGE && merge_found) begin
      count_nxt = count_r - vpfa_pkg::CNT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vpfa_pkg::S_IDLE;
      scan_cnt_r  <= '0;
      count_r     <= vpfa_pkg::CNT_W'(1);
      fit_mode_r  <= vpfa_pkg::FIT_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      count_r    <= count_nxt;
      if (cfg_xfer && cfg_ch.index == vpfa_pkg::CFG_FIT_MODE) begin
        fit_mode_r <= cfg_ch.data[1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r    <= in_ch.opcode;
      owner_r <= vpfa_pkg::OWNER_BITS'(in_ch.owner_id);
      req_r   <= req_in;
    end
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    res_freed_r  <= res_freed_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_start_r  <= vpfa_pkg::START_W'(res_start_r);
      out_freed_r  <= res_freed_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.block_start   = out_start_r;
  assign out_ch.regions_freed = out_freed_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= vpfa_pkg::CNT_W'(vpfa_pkg::MAX_REGIONS)))
    else $error("region count out of range");

  a_merge_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vpfa_pkg::S_MERGE) |=>
      (count_r < $past(count_r)) || (state_r == vpfa_pkg::S_DONE))
    else $error("merge step made no progress");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == vpfa_pkg::S_DONE))
    else $error("result raised outside the result state");

  a_split_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vpfa_pkg::S_APPLY && op_r == vpfa_pkg::OP_ALLOC && split_ok) |=>
      (count_r == $past(count_r) + vpfa_pkg::CNT_W'(1)))
    else $error("split did not add a region");
`endif

endmodule
